// ----- hw/rtl/tgdg_pkg.sv -----
`timescale 1ns / 1ps
package tgdg_pkg;

  localparam int SAMPLE_W   = 10;
  localparam int DUTY_W     = 8;
  localparam int LIMIT_W    = 8;
  localparam int TEMP_W     = 12;
  localparam int CODE_W     = 2;
  localparam int REG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  // Averaged reading scaled by 250, then divided by 1023 through a reciprocal.
  localparam int SCALED_W  = 18;
  localparam int QUOT_W    = 8;
  localparam int DEG_W     = 9;
  localparam int DIV_MUL_W = 19;
  localparam logic [DIV_MUL_W-1:0] DIV_MUL = 19'd262401;
  localparam int DIV_SHIFT = 28;
  localparam logic [SCALED_W-1:0] ZERO_POINT = 18'd51150;
  localparam logic signed [DEG_W-1:0] OFFSET_DEG = 9'sd50;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_OVER_LIMIT = 3'd0,
    REG_DUTY_ONE   = 3'd1,
    REG_DUTY_TWO   = 3'd2,
    REG_DUTY_THREE = 3'd3,
    REG_DUTY_FOUR  = 3'd4,
    REG_RED        = 3'd5,
    REG_BLUE       = 3'd6,
    REG_FAN        = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] over_limit_c;
    logic [DUTY_W-1:0]  duty_one;
    logic [DUTY_W-1:0]  duty_two;
    logic [DUTY_W-1:0]  duty_three;
    logic [DUTY_W-1:0]  duty_four;
    logic               red_request;
    logic               blue_request;
    logic               fan_request;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic valid;
  } queue_status_t;

endpackage

// ----- hw/rtl/thermal_guard_drive_gate_unit.sv -----
`timescale 1ns / 1ps
// Channel   | Handshake              | Beat contents
// ----------+------------------------+------------------------------------------------
// input     | in_valid / in_stall    | func, sample
// output    | out_valid / out_stall  | temp_one, temp_two, over_code, over_latched,
//           |                        | fresh_reading, drive_one..four, red/blue/fan_out
// config    | cfg_we                 | cfg_index, cfg_data
//
// Every part handles one beat a cycle, so with no output stall a new beat is
// taken each cycle. A beat is written into the four-entry queue at the edge
// that accepts it, and its result then passes through a stage for the channel
// averages, a stage for the divide by 1023, and the output register that also
// holds the latch and the last temperatures.
// Reset is synchronous and active high; no clearing pass is needed.
// A stall on the output backs up the pipeline, then fills the queue, and
// only then raises in_stall.
module thermal_guard_drive_gate_unit #(
  parameter int SAMPLES_PER_AVERAGE = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                func,
  input  logic [tgdg_pkg::SAMPLE_W-1:0]       sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [tgdg_pkg::TEMP_W-1:0]  temp_one,
  output logic signed [tgdg_pkg::TEMP_W-1:0]  temp_two,
  output logic [tgdg_pkg::CODE_W-1:0]         over_code,
  output logic                                over_latched,
  output logic                                fresh_reading,
  output logic [tgdg_pkg::DUTY_W-1:0]         drive_one,
  output logic [tgdg_pkg::DUTY_W-1:0]         drive_two,
  output logic [tgdg_pkg::DUTY_W-1:0]         drive_three,
  output logic [tgdg_pkg::DUTY_W-1:0]         drive_four,
  output logic                                red_out,
  output logic                                blue_out,
  output logic                                fan_out,
  input  logic                                cfg_we,
  input  logic [tgdg_pkg::REG_IDX_W-1:0]      cfg_index,
  input  logic [tgdg_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // Each queue entry carries the clear flag, the reading-complete flag and
  // the two channel sums as they stood when the pair finished.
  localparam int SUM_W   = tgdg_pkg::SAMPLE_W + $clog2(SAMPLES_PER_AVERAGE);
  localparam int ENTRY_W = 2 + 2 * SUM_W;

  tgdg_pkg::cfg_t          cfg;
  tgdg_pkg::queue_status_t queue_status;
  logic                    push;
  logic                    pop;
  logic [ENTRY_W-1:0]      push_data;
  logic [ENTRY_W-1:0]      head_data;

  // Configuration registers: write only while the block is idle (the block does
  // not enforce it), so the back end may read them directly to form a result.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.over_limit_c <= 8'd65;
      cfg.duty_one     <= '0;
      cfg.duty_two     <= '0;
      cfg.duty_three   <= '0;
      cfg.duty_four    <= '0;
      cfg.red_request  <= 1'b0;
      cfg.blue_request <= 1'b0;
      cfg.fan_request  <= 1'b1;
    end else if (cfg_we) begin
      case (tgdg_pkg::reg_idx_t'(cfg_index))
        tgdg_pkg::REG_OVER_LIMIT: cfg.over_limit_c <= cfg_data;
        tgdg_pkg::REG_DUTY_ONE:   cfg.duty_one     <= cfg_data;
        tgdg_pkg::REG_DUTY_TWO:   cfg.duty_two     <= cfg_data;
        tgdg_pkg::REG_DUTY_THREE: cfg.duty_three   <= cfg_data;
        tgdg_pkg::REG_DUTY_FOUR:  cfg.duty_four    <= cfg_data;
        tgdg_pkg::REG_RED:        cfg.red_request  <= cfg_data[0];
        tgdg_pkg::REG_BLUE:       cfg.blue_request <= cfg_data[0];
        tgdg_pkg::REG_FAN:        cfg.fan_request  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Front end: steers samples to the two channel sums and flags the beat
  // that completes a reading.
  tgdg_front #(
    .SAMPLES_PER_AVERAGE(SAMPLES_PER_AVERAGE)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .func         (func),
    .sample       (sample),
    .queue_status (queue_status),
    .in_stall     (in_stall),
    .push         (push),
    .entry        (push_data)
  );

  tgdg_fifo #(
    .DATA_W(ENTRY_W)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head_data (head_data),
    .status    (queue_status)
  );

  // Back end: averages, converts to tenths of a degree, checks the limit,
  // keeps the over-temperature latch and gates the drive outputs.
  tgdg_back #(
    .SAMPLES_PER_AVERAGE(SAMPLES_PER_AVERAGE)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .queue_status  (queue_status),
    .head_data     (head_data),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .temp_one      (temp_one),
    .temp_two      (temp_two),
    .over_code     (over_code),
    .over_latched  (over_latched),
    .fresh_reading (fresh_reading),
    .drive_one     (drive_one),
    .drive_two     (drive_two),
    .drive_three   (drive_three),
    .drive_four    (drive_four),
    .red_out       (red_out),
    .blue_out      (blue_out),
    .fan_out       (fan_out)
  );

endmodule

// ----- hw/rtl/tgdg_front.sv -----
`timescale 1ns / 1ps
module tgdg_front #(
  parameter int SAMPLES_PER_AVERAGE = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic                             func,
  input  logic [tgdg_pkg::SAMPLE_W-1:0]    sample,
  input  tgdg_pkg::queue_status_t          queue_status,
  output logic                             in_stall,
  output logic                             push,
  output logic [2+2*(tgdg_pkg::SAMPLE_W+$clog2(SAMPLES_PER_AVERAGE))-1:0] entry
);

  localparam int CNT_W = $clog2(SAMPLES_PER_AVERAGE);
  localparam int SUM_W = tgdg_pkg::SAMPLE_W + CNT_W;
  localparam logic [CNT_W-1:0] LAST_PAIR = CNT_W'(SAMPLES_PER_AVERAGE - 1);

  typedef struct packed {
    logic             clear;
    logic             fresh;
    logic [SUM_W-1:0] sum_one;
    logic [SUM_W-1:0] sum_two;
  } entry_t;

  logic             channel_sel;
  logic [SUM_W-1:0] sum_one;
  logic [SUM_W-1:0] sum_two;
  logic [CNT_W-1:0] pair_count;
  logic [SUM_W-1:0] sum_two_next;
  logic             pair_done;
  entry_t           entry_s;

  assign in_stall     = queue_status.full;
  assign push         = in_valid && !queue_status.full;
  assign sum_two_next = sum_two + SUM_W'(sample);
  assign pair_done    = !func && channel_sel && (pair_count == LAST_PAIR);

  always_comb begin
    entry_s.clear   = func;
    entry_s.fresh   = pair_done;
    entry_s.sum_one = sum_one;
    entry_s.sum_two = sum_two_next;
  end
  assign entry = entry_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_sel <= 1'b0;
      sum_one     <= '0;
      sum_two     <= '0;
      pair_count  <= '0;
    end else if (push && !func) begin
      channel_sel <= !channel_sel;
      if (!channel_sel) begin
        sum_one <= sum_one + SUM_W'(sample);
      end else if (pair_done) begin
        sum_one    <= '0;
        sum_two    <= '0;
        pair_count <= '0;
      end else begin
        sum_two    <= sum_two_next;
        pair_count <= pair_count + 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/tgdg_fifo.sv -----
`timescale 1ns / 1ps
module tgdg_fifo #(
  parameter int DATA_W = 30
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  logic [DATA_W-1:0]       push_data,
  input  logic                    pop,
  output logic [DATA_W-1:0]       head_data,
  output tgdg_pkg::queue_status_t status
);

  localparam int DEPTH = tgdg_pkg::QUEUE_DEPTH;
  localparam int PTR_W = tgdg_pkg::QPTR_W;

  logic [DATA_W-1:0] store [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [PTR_W:0]    count;

  assign status.full  = (count == (PTR_W+1)'(DEPTH));
  assign status.valid = (count != '0);
  assign head_data    = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/tgdg_back.sv -----
`timescale 1ns / 1ps
module tgdg_back #(
  parameter int SAMPLES_PER_AVERAGE = 16
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  tgdg_pkg::cfg_t                          cfg,
  input  tgdg_pkg::queue_status_t                 queue_status,
  input  logic [2+2*(tgdg_pkg::SAMPLE_W+$clog2(SAMPLES_PER_AVERAGE))-1:0] head_data,
  output logic                                    pop,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [tgdg_pkg::TEMP_W-1:0]      temp_one,
  output logic signed [tgdg_pkg::TEMP_W-1:0]      temp_two,
  output logic [tgdg_pkg::CODE_W-1:0]             over_code,
  output logic                                    over_latched,
  output logic                                    fresh_reading,
  output logic [tgdg_pkg::DUTY_W-1:0]             drive_one,
  output logic [tgdg_pkg::DUTY_W-1:0]             drive_two,
  output logic [tgdg_pkg::DUTY_W-1:0]             drive_three,
  output logic [tgdg_pkg::DUTY_W-1:0]             drive_four,
  output logic                                    red_out,
  output logic                                    blue_out,
  output logic                                    fan_out
);

  localparam int L      = $clog2(SAMPLES_PER_AVERAGE);
  localparam int SUM_W  = tgdg_pkg::SAMPLE_W + L;
  localparam int K      = SUM_W + L;
  localparam int M_W    = SUM_W + 2;
  localparam int PROD_W = SUM_W + M_W;
  localparam logic [M_W-1:0] AVG_MUL =
    M_W'(((64'd1 << K) + SAMPLES_PER_AVERAGE - 1) / SAMPLES_PER_AVERAGE);
  localparam int SW     = tgdg_pkg::SCALED_W;
  localparam int QW     = tgdg_pkg::QUOT_W;
  localparam int DW     = tgdg_pkg::DEG_W;
  localparam int TW     = tgdg_pkg::TEMP_W;
  localparam int DPROD_W = SW + tgdg_pkg::DIV_MUL_W;

  typedef struct packed {
    logic             clear;
    logic             fresh;
    logic [SUM_W-1:0] sum_one;
    logic [SUM_W-1:0] sum_two;
  } entry_t;

  entry_t head;
  assign head = head_data;

  // Stage one: channel averages.
  logic                               s1_valid, s1_clear, s1_fresh;
  logic [tgdg_pkg::SAMPLE_W-1:0]      s1_avg_one, s1_avg_two;
  logic [PROD_W-1:0]                  avg_prod_one, avg_prod_two;
  // Stage two: quotient by 1023 of the scaled average.
  logic                               s2_valid, s2_clear, s2_fresh;
  logic [SW-1:0]                      s2_p_one, s2_p_two;
  logic [QW-1:0]                      s2_fq_one, s2_fq_two;
  logic [SW-1:0]                      p_one, p_two;
  logic [DPROD_W-1:0]                 div_prod_one, div_prod_two;
  // Final stage.
  logic                               s1_ready, s2_ready, o_ready;
  logic signed [DW-1:0]               deg_one, deg_two;
  logic signed [TW-1:0]               tenths_one, tenths_two;
  logic [tgdg_pkg::CODE_W-1:0]        code_now;
  logic                               latch_next;
  logic [tgdg_pkg::CODE_W-1:0]        code_next;

  assign o_ready  = !out_valid || !out_stall;
  assign s2_ready = !s2_valid || o_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign pop      = queue_status.valid && s1_ready;

  assign avg_prod_one = PROD_W'(head.sum_one) * PROD_W'(AVG_MUL);
  assign avg_prod_two = PROD_W'(head.sum_two) * PROD_W'(AVG_MUL);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_clear   <= head.clear;
      s1_fresh   <= head.fresh;
      s1_avg_one <= avg_prod_one[K +: tgdg_pkg::SAMPLE_W];
      s1_avg_two <= avg_prod_two[K +: tgdg_pkg::SAMPLE_W];
    end
  end

  // Scale by 250 with shifts: 256 - 4 - 2.
  assign p_one = (SW'(s1_avg_one) << 8) - (SW'(s1_avg_one) << 2) - (SW'(s1_avg_one) << 1);
  assign p_two = (SW'(s1_avg_two) << 8) - (SW'(s1_avg_two) << 2) - (SW'(s1_avg_two) << 1);
  assign div_prod_one = DPROD_W'(p_one) * DPROD_W'(tgdg_pkg::DIV_MUL);
  assign div_prod_two = DPROD_W'(p_two) * DPROD_W'(tgdg_pkg::DIV_MUL);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready) begin
      s2_clear  <= s1_clear;
      s2_fresh  <= s1_fresh;
      s2_p_one  <= p_one;
      s2_p_two  <= p_two;
      s2_fq_one <= div_prod_one[tgdg_pkg::DIV_SHIFT +: QW];
      s2_fq_two <= div_prod_two[tgdg_pkg::DIV_SHIFT +: QW];
    end
  end

  // Degrees rounded toward zero: below the zero point a nonzero remainder
  // moves the floored quotient up by one.
  function automatic logic signed [DW-1:0] to_deg(input logic [SW-1:0] p,
                                                  input logic [QW-1:0] fq);
    logic [SW-1:0] back_mul;
    logic          adj;
    back_mul = (SW'(fq) << 10) - SW'(fq);
    adj      = (p < tgdg_pkg::ZERO_POINT) && (p != back_mul);
    return $signed({1'b0, fq}) - tgdg_pkg::OFFSET_DEG + $signed({{(DW-1){1'b0}}, adj});
  endfunction

  assign deg_one    = to_deg(s2_p_one, s2_fq_one);
  assign deg_two    = to_deg(s2_p_two, s2_fq_two);
  assign tenths_one = (TW'(deg_one) <<< 3) + (TW'(deg_one) <<< 1);
  assign tenths_two = (TW'(deg_two) <<< 3) + (TW'(deg_two) <<< 1);

  // Comparing whole degrees with the limit is the same as comparing tenths.
  assign code_now[0] = deg_one >= $signed({1'b0, cfg.over_limit_c});
  assign code_now[1] = deg_two >= $signed({1'b0, cfg.over_limit_c});

  always_comb begin
    latch_next = over_latched;
    code_next  = over_code;
    if (s2_clear) begin
      latch_next = 1'b0;
      code_next  = '0;
    end else if (s2_fresh && (code_now != '0)) begin
      latch_next = 1'b1;
      code_next  = code_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      temp_one      <= '0;
      temp_two      <= '0;
      over_code     <= '0;
      over_latched  <= 1'b0;
      fresh_reading <= 1'b0;
      drive_one     <= '0;
      drive_two     <= '0;
      drive_three   <= '0;
      drive_four    <= '0;
      red_out       <= 1'b0;
      blue_out      <= 1'b0;
      fan_out       <= 1'b0;
    end else if (o_ready) begin
      out_valid <= s2_valid;
      if (s2_valid) begin
        if (!s2_clear && s2_fresh) begin
          temp_one <= tenths_one;
          temp_two <= tenths_two;
        end
        over_code     <= code_next;
        over_latched  <= latch_next;
        fresh_reading <= !s2_clear && s2_fresh;
        drive_one     <= latch_next ? '0 : cfg.duty_one;
        drive_two     <= latch_next ? '0 : cfg.duty_two;
        drive_three   <= latch_next ? '0 : cfg.duty_three;
        drive_four    <= latch_next ? '0 : cfg.duty_four;
        red_out       <= !latch_next && cfg.red_request;
        blue_out      <= !latch_next && cfg.blue_request;
        fan_out       <= !latch_next && cfg.fan_request;
      end
    end
  end

endmodule

// ----- bench/thermal_guard_drive_gate_unit_tb.sv -----
`timescale 1ns / 1ps
module thermal_guard_drive_gate_unit_tb;

  // Item kinds on the func field.
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_CLEAR  = 1'b1;

  localparam int PAIRS_PER_READING = 16;
  localparam int ADC_MAX           = 1023;
  localparam int CYCLE_LIMIT       = 600000;
  localparam int DRAIN_CYCLES      = 16;
  localparam int SEGMENT_BEATS     = 270;
  localparam int SEGMENTS          = 6;

  // How the samples of one averaging set are drawn in the random part.
  typedef enum int {SET_SPREAD, SET_FULL, SET_FIXED, SET_NEAR} set_style_t;

  // One output beat, field by field, at the widths of the ports.
  typedef struct packed {
    logic [tgdg_pkg::TEMP_W-1:0] t1;
    logic [tgdg_pkg::TEMP_W-1:0] t2;
    logic [tgdg_pkg::CODE_W-1:0] code;
    logic                        latched;
    logic                        fresh;
    logic [tgdg_pkg::DUTY_W-1:0] d1;
    logic [tgdg_pkg::DUTY_W-1:0] d2;
    logic [tgdg_pkg::DUTY_W-1:0] d3;
    logic [tgdg_pkg::DUTY_W-1:0] d4;
    logic                        red;
    logic                        blue;
    logic                        fan;
  } status_beat_t;

  // A directed row sends a run of beats of one kind. Sample beats take s_one or
  // s_two depending on which sensor is due next. When typed is set, the last
  // beat of the row is checked against want instead of the predictor.
  typedef struct packed {
    logic                          op;
    logic [tgdg_pkg::SAMPLE_W-1:0] s_one;
    logic [tgdg_pkg::SAMPLE_W-1:0] s_two;
    logic [6:0]                    beats;
    logic                          typed;
    status_beat_t                  want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic func;
  logic [tgdg_pkg::SAMPLE_W-1:0] sample;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [tgdg_pkg::TEMP_W-1:0] temp_one;
  logic signed [tgdg_pkg::TEMP_W-1:0] temp_two;
  logic [tgdg_pkg::CODE_W-1:0] over_code;
  logic over_latched;
  logic fresh_reading;
  logic [tgdg_pkg::DUTY_W-1:0] drive_one;
  logic [tgdg_pkg::DUTY_W-1:0] drive_two;
  logic [tgdg_pkg::DUTY_W-1:0] drive_three;
  logic [tgdg_pkg::DUTY_W-1:0] drive_four;
  logic red_out;
  logic blue_out;
  logic fan_out;
  logic cfg_we;
  logic [tgdg_pkg::REG_IDX_W-1:0] cfg_index;
  logic [tgdg_pkg::CFG_DATA_W-1:0] cfg_data;

  thermal_guard_drive_gate_unit #(
    .SAMPLES_PER_AVERAGE(PAIRS_PER_READING)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .func(func),
    .sample(sample),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .temp_one(temp_one),
    .temp_two(temp_two),
    .over_code(over_code),
    .over_latched(over_latched),
    .fresh_reading(fresh_reading),
    .drive_one(drive_one),
    .drive_two(drive_two),
    .drive_three(drive_three),
    .drive_four(drive_four),
    .red_out(red_out),
    .blue_out(blue_out),
    .fan_out(fan_out),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // The clock period is 4 ns.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Our own copy of the guard: sampling state, latch and configuration.
  logic                               chan_two_next;
  logic [13:0]                        acc_one;
  logic [13:0]                        acc_two;
  logic [3:0]                         pairs_done;
  logic signed [tgdg_pkg::TEMP_W-1:0] held_one;
  logic signed [tgdg_pkg::TEMP_W-1:0] held_two;
  logic [tgdg_pkg::CODE_W-1:0]        held_code;
  logic                               held_latch;
  logic [tgdg_pkg::LIMIT_W-1:0]       lim_c;
  logic [tgdg_pkg::DUTY_W-1:0]        duty_q [4];
  logic                               red_q;
  logic                               blue_q;
  logic                               fan_q;

  // Status beats owed by the block, oldest first.
  status_beat_t status_due [$];

  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 36;
  int recv_stall_pct = 76;

  // Drawing state of the current averaging set in the random part.
  set_style_t set_style = SET_SPREAD;
  int lvl_one = 0;
  int lvl_two = 0;
  int spread = 0;

  function automatic int clamp_adc(input int v);
    if (v < 0) return 0;
    if (v > ADC_MAX) return ADC_MAX;
    return v;
  endfunction

  // Degrees C times ten; SystemVerilog integer division truncates toward
  // zero, which is exactly the rounding the conversion calls for.
  function automatic logic signed [tgdg_pkg::TEMP_W-1:0] tenths_of(
      input logic [tgdg_pkg::SAMPLE_W-1:0] avg);
    int num;
    num = int'(avg) * 2500 - 511500;
    return tgdg_pkg::TEMP_W'((num / 10230) * 10);
  endfunction

  task automatic reset_guard_model();
    chan_two_next = 1'b0;
    acc_one = '0;
    acc_two = '0;
    pairs_done = '0;
    held_one = '0;
    held_two = '0;
    held_code = '0;
    held_latch = 1'b0;
    lim_c = 8'd65;
    for (int i = 0; i < 4; i++) duty_q[i] = '0;
    red_q = 1'b0;
    blue_q = 1'b0;
    fan_q = 1'b1;
  endtask

  // Advance the guard by one accepted beat and return the status it reports.
  task automatic advance_guard(input logic op, input logic [tgdg_pkg::SAMPLE_W-1:0] s,
                               output status_beat_t r);
    logic [tgdg_pkg::CODE_W-1:0] over;
    logic fresh;
    int lim;
    fresh = 1'b0;
    if (op == FUNC_CLEAR) begin
      held_latch = 1'b0;
      held_code = '0;
    end else if (!chan_two_next) begin
      acc_one = acc_one + 14'(s);
      chan_two_next = 1'b1;
    end else begin
      acc_two = acc_two + 14'(s);
      chan_two_next = 1'b0;
      if (pairs_done == 4'(PAIRS_PER_READING - 1)) begin
        pairs_done = '0;
        held_one = tenths_of(tgdg_pkg::SAMPLE_W'(acc_one / 14'(PAIRS_PER_READING)));
        held_two = tenths_of(tgdg_pkg::SAMPLE_W'(acc_two / 14'(PAIRS_PER_READING)));
        acc_one = '0;
        acc_two = '0;
        lim = int'(lim_c) * 10;
        over = '0;
        if (int'(held_one) >= lim) over[0] = 1'b1;
        if (int'(held_two) >= lim) over[1] = 1'b1;
        // A reading with no overrun leaves the code and the latch alone.
        if (over != '0) begin
          held_code = over;
          held_latch = 1'b1;
        end
        fresh = 1'b1;
      end else begin
        pairs_done = pairs_done + 4'd1;
      end
    end
    // The latch, including one set by this very beat, gates every drive and indicator output.
    r.t1 = held_one;
    r.t2 = held_two;
    r.code = held_code;
    r.latched = held_latch;
    r.fresh = fresh;
    r.d1 = held_latch ? '0 : duty_q[0];
    r.d2 = held_latch ? '0 : duty_q[1];
    r.d3 = held_latch ? '0 : duty_q[2];
    r.d4 = held_latch ? '0 : duty_q[3];
    r.red = held_latch ? 1'b0 : red_q;
    r.blue = held_latch ? 1'b0 : blue_q;
    r.fan = held_latch ? 1'b0 : fan_q;
  endtask

  // Status under the reset configuration: duties, red and blue are zero.
  function automatic status_beat_t reset_cfg_status(input int t1, input int t2,
                                                    input int code, input logic lat,
                                                    input logic fresh, input logic fan);
    status_beat_t r;
    r = '0;
    r.t1 = tgdg_pkg::TEMP_W'(t1);
    r.t2 = tgdg_pkg::TEMP_W'(t2);
    r.code = tgdg_pkg::CODE_W'(code);
    r.latched = lat;
    r.fresh = fresh;
    r.fan = fan;
    return r;
  endfunction

  function automatic plan_row_t plan_row(input logic op, input int s1, input int s2,
                                         input int n, input logic typed,
                                         input status_beat_t want);
    plan_row_t r;
    r.op = op;
    r.s_one = tgdg_pkg::SAMPLE_W'(s1);
    r.s_two = tgdg_pkg::SAMPLE_W'(s2);
    r.beats = 7'(n);
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  // Register writes happen only while no beat is in flight. Bits above a
  // register's width are left random so that the block must ignore them.
  task automatic write_reg(input tgdg_pkg::reg_idx_t idx,
                           input logic [tgdg_pkg::CFG_DATA_W-1:0] d);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = d;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      tgdg_pkg::REG_OVER_LIMIT: lim_c = d;
      tgdg_pkg::REG_DUTY_ONE:   duty_q[0] = d;
      tgdg_pkg::REG_DUTY_TWO:   duty_q[1] = d;
      tgdg_pkg::REG_DUTY_THREE: duty_q[2] = d;
      tgdg_pkg::REG_DUTY_FOUR:  duty_q[3] = d;
      tgdg_pkg::REG_RED:        red_q = d[0];
      tgdg_pkg::REG_BLUE:       blue_q = d[0];
      tgdg_pkg::REG_FAN:        fan_q = d[0];
      default: ;
    endcase
  endtask

  // Offer one beat on the input channel, starting and ending at a falling
  // edge. The valid stays high across back-to-back beats, and the payload
  // holds while the block stalls.
  task automatic send_beat(input logic op, input logic [tgdg_pkg::SAMPLE_W-1:0] s,
                           input logic typed, input status_beat_t want);
    status_beat_t r;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    func = op;
    sample = s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    advance_guard(op, s, r);
    status_due.push_back(typed ? want : r);
    @(negedge clk);
  endtask

  // Choose how the next averaging set is drawn. Near-limit sets aim both
  // channels at the average that lands on the configured limit.
  task automatic pick_set();
    int pick;
    int aim;
    pick = $urandom_range(0, 9);
    if (pick < 5) set_style = SET_SPREAD;
    else if (pick < 7) set_style = SET_FULL;
    else if (pick < 8) set_style = SET_FIXED;
    else set_style = SET_NEAR;
    case (set_style)
      SET_SPREAD: begin
        lvl_one = $urandom_range(0, ADC_MAX);
        lvl_two = $urandom_range(0, ADC_MAX);
        spread = $urandom_range(0, 48);
      end
      SET_FIXED: begin
        lvl_one = $urandom_range(0, 1) ? ADC_MAX : 0;
        lvl_two = $urandom_range(0, 1) ? ADC_MAX : 0;
        spread = 0;
      end
      SET_NEAR: begin
        aim = (int'(lim_c) * 10230 + 511500) / 2500;
        lvl_one = clamp_adc(aim + int'($urandom_range(0, 4)) - 2);
        lvl_two = clamp_adc(aim + int'($urandom_range(0, 4)) - 2);
        spread = 1;
      end
      default: spread = 0;
    endcase
  endtask

  function automatic logic [tgdg_pkg::SAMPLE_W-1:0] draw_sample(input int lvl);
    if (set_style == SET_FULL) return tgdg_pkg::SAMPLE_W'($urandom_range(0, ADC_MAX));
    return tgdg_pkg::SAMPLE_W'(clamp_adc(lvl + int'($urandom_range(0, 2 * spread)) - spread));
  endfunction

  task automatic check_field(input string name, input int want_v, input int got_v);
    if (want_v != got_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
    end
  endtask

  // The receiver stalls at random; the draw is made at the falling edge so
  // the stall is stable when the rising edge samples it.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Every accepted output beat is matched against the oldest owed status.
  always @(posedge clk) begin
    status_beat_t want;
    if (!rst && out_valid && !out_stall) begin
      if (status_due.size() == 0) begin
        errors++;
        $display("%0t: output beat with nothing expected, actual t1=%0d t2=%0d code=%0d",
                 $time, temp_one, temp_two, over_code);
      end else begin
        want = status_due.pop_front();
        check_field("temp_one", $signed(want.t1), temp_one);
        check_field("temp_two", $signed(want.t2), temp_two);
        check_field("over_code", want.code, over_code);
        check_field("over_latched", want.latched, over_latched);
        check_field("fresh_reading", want.fresh, fresh_reading);
        check_field("drive_one", want.d1, drive_one);
        check_field("drive_two", want.d2, drive_two);
        check_field("drive_three", want.d3, drive_three);
        check_field("drive_four", want.d4, drive_four);
        check_field("red_out", want.red, red_out);
        check_field("blue_out", want.blue, blue_out);
        check_field("fan_out", want.fan, fan_out);
      end
    end
  end

  // A run that stops making progress ends here.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    plan_row_t plan [$];
    logic [tgdg_pkg::CFG_DATA_W-1:0] v;
    logic op;
    logic [tgdg_pkg::SAMPLE_W-1:0] s;

    rst = 1'b1;
    in_valid = 1'b0;
    func = FUNC_SAMPLE;
    sample = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    reset_guard_model();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part, run under the reset configuration (limit 65 C, duties
    // zero, fan on). Rows of 31 or 32 beats finish a 16-pair reading.
    // First beat after reset: nothing averaged yet.
    plan.push_back(plan_row(FUNC_SAMPLE, 0, 0, 1, 1'b1,
                            reset_cfg_status(0, 0, 0, 1'b0, 1'b0, 1'b1)));
    // A clear in the middle of a pair, with nothing latched.
    plan.push_back(plan_row(FUNC_CLEAR, ADC_MAX, 0, 1, 1'b1,
                            reset_cfg_status(0, 0, 0, 1'b0, 1'b0, 1'b1)));
    // All-zero readings give the coldest temperature.
    plan.push_back(plan_row(FUNC_SAMPLE, 0, 0, 31, 1'b1,
                            reset_cfg_status(-500, -500, 0, 1'b0, 1'b1, 1'b1)));
    // Full-scale readings: both over, and the new latch gates the same beat.
    plan.push_back(plan_row(FUNC_SAMPLE, ADC_MAX, ADC_MAX, 32, 1'b1,
                            reset_cfg_status(2000, 2000, 3, 1'b1, 1'b1, 1'b0)));
    plan.push_back(plan_row(FUNC_SAMPLE, ADC_MAX, 0, 1, 1'b0, '0));
    // Clearing keeps the temperatures and the half-built pair.
    plan.push_back(plan_row(FUNC_CLEAR, 0, 0, 1, 1'b1,
                            reset_cfg_status(2000, 2000, 0, 1'b0, 1'b0, 1'b1)));
    // Sensor one over, then sensor two over replacing the code while latched.
    plan.push_back(plan_row(FUNC_SAMPLE, ADC_MAX, 0, 31, 1'b0, '0));
    plan.push_back(plan_row(FUNC_SAMPLE, 0, ADC_MAX, 32, 1'b0, '0));
    // A cool reading while latched leaves the code and latch as they were.
    plan.push_back(plan_row(FUNC_SAMPLE, 200, 200, 32, 1'b0, '0));
    plan.push_back(plan_row(FUNC_CLEAR, ADC_MAX, ADC_MAX, 1, 1'b0, '0));
    // Averages one step either side of the limit.
    plan.push_back(plan_row(FUNC_SAMPLE, 471, 470, 32, 1'b0, '0));
    plan.push_back(plan_row(FUNC_CLEAR, 0, 0, 1, 1'b0, '0));
    plan.push_back(plan_row(FUNC_SAMPLE, 470, 471, 32, 1'b0, '0));
    plan.push_back(plan_row(FUNC_CLEAR, 0, 0, 1, 1'b0, '0));
    // Small negative quotients round toward zero, not down.
    plan.push_back(plan_row(FUNC_SAMPLE, 204, 100, 32, 1'b0, '0));
    // A sum that is not a multiple of 16, so the average truncates.
    plan.push_back(plan_row(FUNC_SAMPLE, 500, 500, 31, 1'b0, '0));
    plan.push_back(plan_row(FUNC_SAMPLE, 0, 7, 1, 1'b0, '0));
    plan.push_back(plan_row(FUNC_CLEAR, 0, 0, 1, 1'b0, '0));
    // Complementary bit patterns on the sample field.
    plan.push_back(plan_row(FUNC_SAMPLE, 512, 511, 32, 1'b0, '0));
    plan.push_back(plan_row(FUNC_CLEAR, 0, 0, 1, 1'b0, '0));

    foreach (plan[i]) begin
      for (int k = 0; k < int'(plan[i].beats); k++) begin
        s = chan_two_next ? plan[i].s_two : plan[i].s_one;
        send_beat(plan[i].op, s, plan[i].typed && (k == int'(plan[i].beats) - 1),
                  plan[i].want);
      end
    end
    in_valid = 1'b0;

    // Random part in segments. Each segment starts from an idle block with
    // a fresh configuration: first the highest and the lowest limit, then
    // random settings. The first two segments idle the sender lightly
    // and the receiver heavily, the next two the other way round, and the
    // last two run with no idling at all.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      while (status_due.size() != 0) @(posedge clk);
      @(negedge clk);
      for (int i = 0; i < 8; i++) begin
        case (seg)
          0: v = (i < 5) ? 8'hFF : {7'($urandom), 1'b1};
          1: v = (i < 5) ? 8'h00 : {7'($urandom), 1'b0};
          3: v = 8'($urandom);
          default: v = (i == 0) ? 8'($urandom_range(20, 110)) : 8'($urandom);
        endcase
        write_reg(tgdg_pkg::reg_idx_t'(i), v);
      end
      if (seg < 2) begin
        send_idle_pct = 36;
        recv_stall_pct = 76;
      end else if (seg < 4) begin
        send_idle_pct = 76;
        recv_stall_pct = 36;
      end else begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end

      for (int n = 0; n < SEGMENT_BEATS; n++) begin
        op = ($urandom_range(0, 29) == 0) ? FUNC_CLEAR : FUNC_SAMPLE;
        if (op == FUNC_CLEAR) begin
          s = tgdg_pkg::SAMPLE_W'($urandom);
        end else begin
          if (!chan_two_next && pairs_done == '0) pick_set();
          s = chan_two_next ? draw_sample(lvl_two) : draw_sample(lvl_one);
        end
        send_beat(op, s, 1'b0, '0);
      end
      in_valid = 1'b0;
    end

    // Let the last beats drain, then keep watching for stray output beats.
    while (status_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- thermal_guard_drive_gate_unit.f -----
hw/rtl/tgdg_pkg.sv
hw/rtl/tgdg_front.sv
hw/rtl/tgdg_fifo.sv
hw/rtl/tgdg_back.sv
hw/rtl/thermal_guard_drive_gate_unit.sv
bench/thermal_guard_drive_gate_unit_tb.sv
